>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, skipped while reset is high.
`define ASSERT_CLKD(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/mdc7_pkg.sv
package mdc7_pkg;

   // Request opcodes
   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_REFRESH = 1'b1;

   // Prescaler
   localparam logic [3:0] PRESCALE_TARGET = 4'd10;
   localparam logic [1:0] STEP_ONE        = 2'd1;
   localparam logic [1:0] STEP_TWO        = 2'd2;

   // Switch control codes (bits 7..5)
   localparam logic [2:0] CTRL_STEP2 = 3'b000;
   localparam logic [2:0] CTRL_CLEAR = 3'b001;
   localparam logic [2:0] CTRL_HOLD  = 3'b010;
   localparam logic [2:0] CTRL_STEP1 = 3'b100;

   // Switch mode codes (bits 4..0)
   localparam logic [4:0] MODE_UP        = 5'h00;
   localparam logic [4:0] MODE_DOWN      = 5'h01;
   localparam logic [4:0] MODE_EVEN_UP   = 5'h02;
   localparam logic [4:0] MODE_EVEN_DOWN = 5'h04;
   localparam logic [4:0] MODE_ODD_UP    = 5'h08;
   localparam logic [4:0] MODE_ODD_DOWN  = 5'h10;

   localparam logic [3:0] SEL_ALL_OFF = 4'hf;
   localparam logic [7:0] SEG_ALL_OFF = 8'hff;

   // Four BCD digits, index 0 = units
   typedef logic [3:0][3:0] bcd_type;

   // Add 0..2 modulo 10000
   function automatic bcd_type bcd_add(bcd_type v, logic [1:0] d);
      bcd_type    r;
      logic [4:0] s;
      logic [1:0] c;
      c = d;
      for (int i = 0; i < 4; i++) begin
         s = 5'(v[i]) + 5'(c);
         if (s > 5'd9) begin
            r[i] = 4'(s - 5'd10);
            c    = 2'd1;
         end else begin
            r[i] = s[3:0];
            c    = 2'd0;
         end
      end
      return r;
   endfunction

   // Subtract 0..2 modulo 10000
   function automatic bcd_type bcd_sub(bcd_type v, logic [1:0] d);
      bcd_type    r;
      logic [1:0] b;
      b = d;
      for (int i = 0; i < 4; i++) begin
         if (5'(v[i]) < 5'(b)) begin
            r[i] = 4'(5'(v[i]) + 5'd10 - 5'(b));
            b    = 2'd1;
         end else begin
            r[i] = 4'(5'(v[i]) - 5'(b));
            b    = 2'd0;
         end
      end
      return r;
   endfunction

   // All wrap rules reduce to plain modulo-10000 steps of 1 or 2.
   function automatic bcd_type next_count(bcd_type v, logic [4:0] mode);
      bcd_type r;
      logic    odd;
      odd = v[0][0];
      unique case (mode)
         MODE_UP:        r = bcd_add(v, 2'd1);
         MODE_DOWN:      r = bcd_sub(v, 2'd1);
         MODE_EVEN_UP:   r = bcd_add(v, odd ? 2'd1 : 2'd2);
         MODE_EVEN_DOWN: r = bcd_sub(v, odd ? 2'd1 : 2'd2);
         MODE_ODD_UP:    r = bcd_add(v, odd ? 2'd2 : 2'd1);
         MODE_ODD_DOWN:  r = bcd_sub(v, odd ? 2'd2 : 2'd1);
         default:        r = v;
      endcase
      return r;
   endfunction

   function automatic logic [13:0] bcd_to_bin(bcd_type v);
      return 14'(v[3]) * 14'd1000 + 14'(v[2]) * 14'd100
           + 14'(v[1]) * 14'd10 + 14'(v[0]);
   endfunction

   function automatic logic [3:0] digit_enable(logic [1:0] pos);
      logic [3:0] r;
      unique case (pos)
         2'd0: r = 4'he;
         2'd1: r = 4'hd;
         2'd2: r = 4'hb;
         2'd3: r = 4'h7;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] seven_seg(logic [3:0] d);
      logic [7:0] r;
      unique case (d)
         4'd0:    r = 8'hc0;
         4'd1:    r = 8'hf9;
         4'd2:    r = 8'ha4;
         4'd3:    r = 8'hb0;
         4'd4:    r = 8'h99;
         4'd5:    r = 8'h92;
         4'd6:    r = 8'h82;
         4'd7:    r = 8'hf8;
         4'd8:    r = 8'h80;
         4'd9:    r = 8'h90;
         default: r = SEG_ALL_OFF;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/modal_decimal_counter_seven_seg_top.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_operation, req_switch_port
// rsp       out        rsp_valid/rsp_stall  rsp_count_value, rsp_digit_select,
//                                           rsp_segment_pattern
//
// One transaction in, one transaction out. A request is accepted in any cycle
// the output register is empty or is being drained, so throughput is one
// transaction per clock while rsp_stall stays low; rsp_valid rises in the
// cycle after acceptance. There is a single output register: all state
// update and digit decode sit in one combinational pass in front of it.
// Synchronous active-high reset: count 0, step 1, prescaler 0, scan on units.
// rsp_stall holds the result register and pushes back through req_stall.
`include "assert_macros.svh"

module modal_decimal_counter_seven_seg_top
   import mdc7_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [7:0]  req_switch_port,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [13:0] rsp_count_value,
   output logic [3:0]  rsp_digit_select,
   output logic [7:0]  rsp_segment_pattern
);

   // Architectural state. The count is kept in BCD so the display scan
   // reads a digit directly; the binary value is rebuilt for the response.
   logic [3:0]  presc_ff,  presc_in;
   logic [1:0]  step_ff,   step_in;
   bcd_type     count_ff,  count_in;
   logic [1:0]  scan_ff,   scan_in;

   // Response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [13:0] rsp_count_ff, rsp_count_in;
   logic [3:0]  rsp_sel_ff,   rsp_sel_in;
   logic [7:0]  rsp_seg_ff,   rsp_seg_in;

   logic        req_fire;
   logic        rsp_take;
   logic [3:0]  presc_sum;
   logic [2:0]  ctrl;
   logic [4:0]  mode;

   // Output register frees up the same cycle it is taken.
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;

   assign presc_sum = presc_ff + 4'(step_ff);
   assign ctrl      = req_switch_port[7:5];
   assign mode      = req_switch_port[4:0];

   always_comb begin
      presc_in     = presc_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      rsp_count_in = rsp_count_ff;
      rsp_sel_in   = rsp_sel_ff;
      rsp_seg_in   = rsp_seg_ff;

      if (req_fire) begin
         if (req_operation == OP_TICK) begin
            if (presc_sum >= PRESCALE_TARGET) begin
               // prescaler fired: sample the switches
               presc_in = '0;
               unique case (ctrl)
                  CTRL_CLEAR: count_in = '0;
                  CTRL_HOLD:  count_in = count_ff;
                  CTRL_STEP1: begin
                     step_in  = STEP_ONE;
                     count_in = next_count(count_ff, mode);
                  end
                  CTRL_STEP2: begin
                     step_in  = STEP_TWO;
                     count_in = next_count(count_ff, mode);
                  end
                  default:    count_in = next_count(count_ff, mode);
               endcase
            end else begin
               presc_in = presc_sum;
            end
            rsp_count_in = bcd_to_bin(count_in);
            rsp_sel_in   = SEL_ALL_OFF;
            rsp_seg_in   = SEG_ALL_OFF;
         end else begin
            // display refresh: drive current digit, advance scan
            rsp_count_in = bcd_to_bin(count_ff);
            rsp_sel_in   = digit_enable(scan_ff);
            rsp_seg_in   = seven_seg(count_ff[scan_ff]);
            scan_in      = scan_ff + 2'd1;
         end
      end
   end

   always_comb begin
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         presc_ff     <= '0;
         step_ff      <= STEP_ONE;
         count_ff     <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         presc_ff     <= presc_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
      rsp_sel_ff   <= rsp_sel_in;
      rsp_seg_ff   <= rsp_seg_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_count_value     = rsp_count_ff;
   assign rsp_digit_select    = rsp_sel_ff;
   assign rsp_segment_pattern = rsp_seg_ff;

   // BCD digits never leave 0..9
   `ASSERT_CLKD(a_bcd_digits, (count_ff[0] <= 4'd9) && (count_ff[1] <= 4'd9) && (count_ff[2] <= 4'd9) && (count_ff[3] <= 4'd9), "count digit out of range")
   // prescaler always below its firing point
   `ASSERT_CLKD(a_presc_range, presc_ff < PRESCALE_TARGET, "prescaler out of range")
   // step size only ever 1 or 2
   `ASSERT_CLKD(a_step_legal, (step_ff == STEP_ONE) || (step_ff == STEP_TWO), "bad step size")
   // a refresh moves the scan on by one digit
   `ASSERT_CLKD(a_scan_advance, (req_fire && (req_operation == OP_REFRESH)) |=> (scan_ff == $past(scan_ff) + 2'd1), "scan did not advance")
   // a shown digit select enables exactly one digit
   `ASSERT_CLKD(a_one_digit, (rsp_valid_ff && (rsp_sel_ff != SEL_ALL_OFF)) |-> ($countones(~rsp_sel_ff) == 1), "digit select not one-cold")

endmodule

>>> tb/tb.sv
`default_nettype none

module tb;
   import mdc7_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // A control code the block does not decode: step size stays, mode acts.
   localparam logic [2:0] CTRL_UNLISTED = 3'b111;

   localparam int COUNT_TOP      = 9999;
   localparam int COUNT_SPAN     = 10000;
   localparam int ODD_DOWN_START = 10001;

   // Cycles with no transaction on either channel before the run is called dead.
   localparam int STALL_LIMIT = 2000;
   // Clocks to wait after the expected queue empties, as margin over the single output register.
   localparam int DRAIN_CYCLES = 4;

   typedef struct packed {
      logic [13:0] count_value;
      logic [3:0]  digit_select;
      logic [7:0]  segment_pattern;
   } readout_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_operation;
   logic [7:0]  req_switch_port;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [13:0] rsp_count_value;
   logic [3:0]  rsp_digit_select;
   logic [7:0]  rsp_segment_pattern;

   modal_decimal_counter_seven_seg_top i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_switch_port     (req_switch_port),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_count_value     (rsp_count_value),
      .rsp_digit_select    (rsp_digit_select),
      .rsp_segment_pattern (rsp_segment_pattern)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ------------------------------------------------------------------
   // Counter/display model. Mirrors the block's architectural state and
   // is advanced once per accepted request transaction.
   // ------------------------------------------------------------------
   logic [3:0]  model_prescale;
   logic [1:0]  model_step;
   logic [13:0] model_count;
   logic [1:0]  model_scan;

   readout_type expected_readouts[$];

   int mismatch_count;
   int items_sent;
   int sender_idle_pct;
   int receiver_stall_pct;
   int quiet_cycles;

   // One counting step over 0..9999 with the wrap rule of each mode.
   function automatic logic [13:0] count_step(logic [13:0] cur, logic [4:0] mode);
      int v;
      v = cur;
      case (mode)
         MODE_UP: begin
            v = v + 1;
            if (v > COUNT_TOP) v = 0;
         end
         MODE_DOWN: begin
            if (v == 0) v = COUNT_SPAN;
            v = v - 1;
         end
         MODE_EVEN_UP: begin
            v = (v % 2 != 0) ? v + 1 : v + 2;
            if (v > COUNT_TOP - 1) v = 0;
         end
         MODE_EVEN_DOWN: begin
            if (v == 0) v = COUNT_SPAN;
            v = (v % 2 != 0) ? v - 1 : v - 2;
         end
         MODE_ODD_UP: begin
            v = (v % 2 != 0) ? v + 2 : v + 1;
            if (v > COUNT_TOP) v = 1;
         end
         MODE_ODD_DOWN: begin
            if (v <= 1) v = ODD_DOWN_START;
            v = (v % 2 != 0) ? v - 2 : v - 1;
         end
         default: ;
      endcase
      return 14'(v);
   endfunction

   function automatic logic [3:0] scan_enable(logic [1:0] pos);
      case (pos)
         2'd0:    return 4'he;
         2'd1:    return 4'hd;
         2'd2:    return 4'hb;
         default: return 4'h7;
      endcase
   endfunction

   function automatic logic [7:0] digit_pattern(int d);
      case (d)
         0:       return 8'hc0;
         1:       return 8'hf9;
         2:       return 8'ha4;
         3:       return 8'hb0;
         4:       return 8'h99;
         5:       return 8'h92;
         6:       return 8'h82;
         7:       return 8'hf8;
         8:       return 8'h80;
         default: return 8'h90;
      endcase
   endfunction

   // True when the next timer tick will sample the switches.
   function automatic bit tick_fires();
      return (5'(model_prescale) + 5'(model_step)) >= 5'(PRESCALE_TARGET);
   endfunction

   // Switch sample: control bits first, then the mode unless frozen.
   task automatic sample_switches(logic [7:0] sw);
      logic frozen;
      frozen = 1'b0;
      case (sw[7:5])
         CTRL_CLEAR: begin
            model_count = '0;
            frozen = 1'b1;
         end
         CTRL_HOLD:  frozen = 1'b1;
         CTRL_STEP1: model_step = STEP_ONE;
         CTRL_STEP2: model_step = STEP_TWO;
         default: ;
      endcase
      if (!frozen) model_count = count_step(model_count, sw[4:0]);
   endtask

   // Advance the model by one request and queue the readout it produces.
   task automatic predict_readout(logic op, logic [7:0] sw);
      readout_type r;
      int          divisor;
      r.digit_select    = SEL_ALL_OFF;
      r.segment_pattern = SEG_ALL_OFF;
      if (op == OP_TICK) begin
         model_prescale = 4'(model_prescale + model_step);
         if (model_prescale >= PRESCALE_TARGET) begin
            model_prescale = '0;
            sample_switches(sw);
         end
      end else begin
         divisor = 1;
         for (int i = 0; i < int'(model_scan); i++) divisor = divisor * 10;
         r.digit_select    = scan_enable(model_scan);
         r.segment_pattern = digit_pattern((int'(model_count) / divisor) % 10);
         model_scan = model_scan + 2'd1;
      end
      r.count_value = model_count;
      expected_readouts.push_back(r);
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("tb: mismatch %s: got %0d, expected %0d", what, got, want);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------
   // Request driver. Entered and left at a falling edge; valid is left
   // high so back-to-back transactions never drop it in between.
   // ------------------------------------------------------------------
   task automatic send_item(logic op, logic [7:0] sw);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_switch_port <= sw;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_readout(op, sw);
      items_sent++;
      @(negedge clock);
   endtask

   // Pad with ticks carrying random (ignored) switches until the next tick
   // samples, then send that tick with the chosen switch byte.
   task automatic fire_with(logic [7:0] sw);
      while (!tick_fires()) send_item(OP_TICK, 8'($urandom_range(255)));
      send_item(OP_TICK, sw);
   endtask

   // One full scan: units, tens, hundreds, thousands (from wherever it is).
   task automatic scan_display();
      repeat (4) send_item(OP_REFRESH, 8'($urandom_range(255)));
   endtask

   // ------------------------------------------------------------------
   // Receiver: random backpressure, changed at the falling edge.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // Result checker, sampled at the rising edge.
   always @(posedge clock) begin
      readout_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_readouts.size() == 0) begin
            report_mismatch("unexpected result, count", rsp_count_value, 0);
         end else begin
            want = expected_readouts.pop_front();
            if (rsp_count_value !== want.count_value)
               report_mismatch("count_value", rsp_count_value, want.count_value);
            if (rsp_digit_select !== want.digit_select)
               report_mismatch("digit_select", rsp_digit_select, want.digit_select);
            if (rsp_segment_pattern !== want.segment_pattern)
               report_mismatch("segment_pattern", rsp_segment_pattern,
                               want.segment_pattern);
         end
      end
   end

   // Watchdog: cycles with no transaction on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("tb: FAIL");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Right after reset every digit reads 0, units first.
   task automatic test_reset_readout();
      scan_display();
   endtask

   // Wrap corners: down from 0, odd-up from 9999 under an unlisted control
   // code, odd-down from 1, then a scan of 9999.
   task automatic test_wrap_corners();
      fire_with({CTRL_STEP2, MODE_DOWN});
      fire_with({CTRL_UNLISTED, MODE_ODD_UP});
      fire_with({CTRL_STEP2, MODE_ODD_DOWN});
      scan_display();
   endtask

   // Mostly well-formed traffic: tick runs that end on a meaningful switch
   // sample, full display scans, and some single random transactions.
   task automatic test_random_traffic(int send_pct, int recv_pct, int n_items);
      int          stop_at;
      int          pick;
      logic [2:0]  ctrl;
      logic [4:0]  mode;
      sender_idle_pct    = send_pct;
      receiver_stall_pct = recv_pct;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            case ($urandom_range(9))
               0, 1:    ctrl = CTRL_STEP2;
               2, 3:    ctrl = CTRL_STEP1;
               4:       ctrl = CTRL_CLEAR;
               5:       ctrl = CTRL_HOLD;
               default: ctrl = 3'($urandom_range(7));
            endcase
            case ($urandom_range(9))
               0:       mode = MODE_UP;
               1:       mode = MODE_DOWN;
               2:       mode = MODE_EVEN_UP;
               3:       mode = MODE_EVEN_DOWN;
               4:       mode = MODE_ODD_UP;
               5:       mode = MODE_ODD_DOWN;
               6, 7:    mode = 5'($urandom_range(31));
               default: mode = ($urandom_range(1) != 0) ? MODE_UP : MODE_DOWN;
            endcase
            fire_with({ctrl, mode});
         end else if (pick < 75) begin
            scan_display();
         end else begin
            send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      // Every input known from time zero.
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_operation      <= OP_TICK;
      req_switch_port    <= '0;
      rsp_stall          <= 1'b0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      mismatch_count     = 0;
      items_sent         = 0;
      model_prescale     = '0;
      model_step         = STEP_ONE;
      model_count        = '0;
      model_scan         = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_readout();
      test_wrap_corners();
      test_random_traffic(33, 55, 570);
      test_random_traffic(55, 33, 570);
      test_random_traffic(0, 0, 560);

      req_valid <= 1'b0;
      while (expected_readouts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_readouts.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
